[hdl/kq_pkg.sv]
// Shared types, constants and the round function for the rolling-code hop decoder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package kq_pkg;

    // Number of decryption rounds, one cell each.
    localparam int ROUNDS = 528;

    // Nonlinear function, indexed by five state bits.
    localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;

    localparam int HOP_W        = 32;
    localparam int COUNTER_W    = 16;
    localparam int KEY_W        = 64;
    localparam int BUTTON_W     = 4;
    localparam int DISC_W       = 10;
    localparam int DISC_LOW_W   = 8;
    localparam int OUT_TDATA_W  = 56;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int PAIR_WINDOW  = 256;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_KEY      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_BUTTON = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_DISC   = 2'd2;

    // One decoded hop as it leaves the check stage.
    typedef struct packed {
        logic [HOP_W-1:0] plain_word;
        logic             hop_ok;
        logic             pair_ok;
    } kq_result_t;

    // Key bit used by round r: bit (15 - r) mod 64.
    function automatic logic [5:0] kq_key_index(input int r);
        kq_key_index = 6'((15 - r) & 63);
    endfunction

    // One decryption round of the nonlinear feedback shift register.
    function automatic logic [HOP_W-1:0] kq_round(input logic [HOP_W-1:0] x,
                                                  input logic             key_bit);
        logic [4:0] sel;
        logic       fb;
        sel = {x[30], x[25], x[19], x[8], x[0]};
        fb  = x[31] ^ x[15] ^ key_bit ^ NLF_TABLE[sel];
        kq_round = {x[HOP_W-2:0], fb};
    endfunction

endpackage

[hdl/kq_round_cell.sv]
// One decryption round cell: applies a single round and hands the word to the next cell.
// Depends on kq_pkg.
`timescale 1ns / 1ps

module kq_round_cell
    import kq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             key_bit,
    input  logic             in_valid,
    input  logic [HOP_W-1:0] in_data,
    output logic             out_valid,
    output logic [HOP_W-1:0] out_data
);

    logic             valid_reg;
    logic [HOP_W-1:0] data_reg;
    logic [HOP_W-1:0] data_next;

    assign data_next = kq_round(in_data, key_bit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/kq_hop_check.sv]
// Button and discriminator check plus the counter pair check against the previous hop.
// Depends on kq_pkg.
`timescale 1ns / 1ps

module kq_hop_check
    import kq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  logic [HOP_W-1:0]    in_data,
    input  logic [BUTTON_W-1:0] expected_button,
    input  logic [DISC_W-1:0]   expected_discriminator,
    output logic                out_valid,
    output kq_result_t          out_result
);

    logic                 valid_reg;
    kq_result_t           result_reg;
    kq_result_t           result_next;
    logic [COUNTER_W-1:0] prev_counter_reg;
    logic                 prev_valid_reg;

    logic [COUNTER_W-1:0] counter;
    logic [DISC_W-1:0]    disc;
    logic                 button_match;
    logic                 disc_match;
    logic [COUNTER_W:0]   diff;
    logic                 hop_ok;
    logic                 pair_ok;

    assign counter      = in_data[COUNTER_W-1:0];
    assign disc         = in_data[COUNTER_W +: DISC_W];
    assign button_match = (in_data[HOP_W-1 -: BUTTON_W] == expected_button);
    // A full match implies a match on the low bits, so the low bits decide.
    assign disc_match   = (disc == expected_discriminator)
                       || (disc[DISC_LOW_W-1:0] == expected_discriminator[DISC_LOW_W-1:0]);
    assign hop_ok       = button_match && disc_match;

    // Counter advance, compared without wrap-around.
    assign diff    = {1'b0, counter} - {1'b0, prev_counter_reg};
    assign pair_ok = hop_ok && prev_valid_reg && (counter > prev_counter_reg)
                  && (diff <= (COUNTER_W+1)'(PAIR_WINDOW));

    always_comb
    begin
        result_next.plain_word = in_data;
        result_next.hop_ok     = hop_ok;
        result_next.pair_ok    = pair_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            prev_valid_reg   <= 1'b0;
            prev_counter_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                prev_valid_reg   <= hop_ok;
                prev_counter_reg <= counter;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[hdl/kq_skid.sv]
// Output register with a skid entry, so the pipeline stall is driven from a register.
// Depends on kq_pkg.
`timescale 1ns / 1ps

module kq_skid
    import kq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  kq_result_t in_result,
    output logic       out_valid,
    input  logic       out_ready,
    output kq_result_t out_result
);

    logic       out_valid_reg;
    kq_result_t out_result_reg;
    logic       skid_valid_reg;
    kq_result_t skid_result_reg;
    logic       out_free;

    assign in_ready = !skid_valid_reg;
    assign out_free = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_result_reg <= skid_valid_reg ? skid_result_reg : in_result;
        end
        else if (in_valid && in_ready)
        begin
            skid_result_reg <= in_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

[hdl/keeloq_hop_decrypt_check.sv]
// Path: a hop transferred into the first round cell passes through the 528 round
// cells, the check stage and the output register before it appears on m_tvalid.
// Throughput: one hop per cycle while the skid entry is empty, set by the row
// of 528 registered round cells that all advance together.
// Reset (rst_n, asynchronous, active low) clears all valid bits, the previous-hop
// state and the configuration registers; no clearing pass is needed.
`timescale 1ns / 1ps

module keeloq_hop_decrypt_check
    import kq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [HOP_W-1:0]       s_tdata,   // [31:0] hop_code
    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [31:0] plain_word, [47:32] sync_counter,
                                              // [48] hop_ok, [49] pair_ok, [55:50] zero
);

    // Configuration registers. Writes are always taken; the user writes them
    // only while no hop is in flight, so the cells read them directly.
    logic [KEY_W-1:0]    device_key_reg;
    logic [BUTTON_W-1:0] expected_button_reg;
    logic [DISC_W-1:0]   expected_disc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_key_reg      <= '0;
            expected_button_reg <= '0;
            expected_disc_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_KEY:
                begin
                    device_key_reg <= cfg_data;
                end
                CFG_EXPECTED_BUTTON:
                begin
                    expected_button_reg <= cfg_data[BUTTON_W-1:0];
                end
                CFG_EXPECTED_DISC:
                begin
                    expected_disc_reg <= cfg_data[DISC_W-1:0];
                end
                default:
                begin
                    // Unknown register index: the write is dropped.
                end
            endcase
        end
    end

    // The whole row of cells and the check stage move together. They stall only
    // when the skid entry is occupied, which is a registered condition, so the
    // output ready never reaches the input ready combinationally.
    logic advance;

    assign s_tready = advance;

    // Stage 0 is the input transfer; stage r+1 is the output of round cell r.
    logic             stage_valid [0:ROUNDS];
    logic [HOP_W-1:0] stage_data  [0:ROUNDS];

    assign stage_valid[0] = s_tvalid;
    assign stage_data[0]  = s_tdata;

    genvar r;
    generate
        for (r = 0; r < ROUNDS; r++)
        begin : g_round
            kq_round_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .key_bit   (device_key_reg[kq_key_index(r)]),
                .in_valid  (stage_valid[r]),
                .in_data   (stage_data[r]),
                .out_valid (stage_valid[r+1]),
                .out_data  (stage_data[r+1])
            );
        end
    endgenerate

    // Check stage: validates the plaintext and tracks the previous hop in order.
    logic       check_valid;
    kq_result_t check_result;

    kq_hop_check u_check
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .advance                (advance),
        .in_valid               (stage_valid[ROUNDS]),
        .in_data                (stage_data[ROUNDS]),
        .expected_button        (expected_button_reg),
        .expected_discriminator (expected_disc_reg),
        .out_valid              (check_valid),
        .out_result             (check_result)
    );

    // Output register with one skid entry.
    kq_result_t out_result;

    kq_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (check_valid),
        .in_ready   (advance),
        .in_result  (check_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {6'b0,
                      out_result.pair_ok,
                      out_result.hop_ok,
                      out_result.plain_word[COUNTER_W-1:0],
                      out_result.plain_word};

endmodule

[hdl/kq_checker.sv]
// Port-level checks for the hop decoder, bound to the top level.
// Depends on kq_pkg and keeloq_hop_decrypt_check.
`timescale 1ns / 1ps

module kq_checker
    import kq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // The counter field is the low half of the plaintext.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:32] == m_tdata[15:0]))
        else $error("sync_counter differs from plain_word low bits");

    // A pair can only be flagged on a hop that passed its own check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[49]) |-> m_tdata[48])
        else $error("pair_ok set without hop_ok");

    // Padding bits stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:50] == '0))
        else $error("m_tdata padding not zero");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind keeloq_hop_decrypt_check kq_checker u_kq_checker (.*);
